FILE: rtl/oahs_pkg.sv
`default_nettype none
package oahs_pkg;
  localparam int SLOTS = 1024;
  localparam int IDX_W = 10;
  localparam int KEY_W = 32;
  localparam int HASH_W = 64;
  localparam int LINEAR_RUN = 9;
  localparam int PERTURB_STEP = 5;
  localparam int ROUND_LIMIT = 64 + SLOTS;
  localparam int ROUND_W = 11;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_ACTIVE = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CONTAINS = 2'd1;
  localparam logic [1:0] CMD_DISCARD = 2'd2;
  localparam logic [1:0] CMD_NEXT = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_MISS = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_END = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_READ, S_CHECK, S_WRITE, S_REPLY
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/open_address_hash_set.sv
`default_nettype none
// Open-addressing hash set of key/hash slots held in on-chip memory.
// A request is accepted on a clock edge with start high and busy low; it
// carries in_command (add, contains, discard, next), in_key, in_hash and
// in_position. Exactly one result follows, shown for one cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// The table mask is to be written by the user through cfg_we/cfg_data
// only while idle; the block leaves this unchecked. Each request walks
// slots one at a time: every visited slot takes a memory read from a
// registered read port, then the compare, followed by an update state
// when the table changes and a result state. The next request can be
// accepted in the result cycle. A next request from a position above the
// mask goes straight to the result state. The probe walk is bounded by
// 1088 starts. After reset the mark memory is swept to empty, one slot a
// cycle, over all 1024 slots, while busy stays high. The key and hash
// memory is never cleared; marks gate every use of it.
module open_address_hash_set
  import oahs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_command,
  input  wire logic [31:0]       in_key,
  input  wire logic [63:0]       in_hash,
  input  wire logic [10:0]       in_position,
  input  wire logic              cfg_we,
  input  wire logic [9:0]        cfg_data,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [9:0]             out_slot_index,
  output logic [31:0]            out_key_out,
  output logic [63:0]            out_hash_out,
  output logic [10:0]            out_next_position,
  output logic [10:0]            out_used_total,
  output logic                   out_grow_wanted
);
  state_t state_r, state_nxt;
  logic [9:0]  mask_r;
  logic [10:0] fill_r, fill_nxt, used_r, used_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] key_r;
  logic [63:0] hash_r;
  logic [63:0] pert_r, pert_nxt;
  logic [9:0]  base_r, base_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  run_r, run_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [9:0]  tomb_r, tomb_nxt;
  logic        tseen_r, tseen_nxt;
  logic [9:0]  wslot_r, wslot_nxt;
  logic [1:0]  wmark_r, wmark_nxt;
  logic        wkh_r, wkh_nxt;
  logic [IDX_W:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [9:0]  si_r, si_nxt;
  logic        kh_sel_r, kh_sel_nxt;
  logic [10:0] np_r, np_nxt;
  logic        gw_r, gw_nxt;

  // Memory ports.
  logic [9:0]  raddr;
  logic [1:0]  mark_rd, mark_wd;
  logic [KEY_W+HASH_W-1:0] slot_rd;
  logic [31:0] key_rd;
  logic [63:0] hash_rd;
  logic        mark_we, kh_we;
  logic [9:0]  mark_wa;

  oahs_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_marks (
    .clk, .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(raddr), .rdata(mark_rd));
  // Key and hash share one slot memory.
  oahs_ram #(.WIDTH(KEY_W+HASH_W), .DEPTH(SLOTS)) u_slots (
    .clk, .we(kh_we), .waddr(wslot_r), .wdata({key_r, hash_r}),
    .raddr(raddr), .rdata(slot_rd));

  assign key_rd = slot_rd[KEY_W+HASH_W-1:HASH_W];
  assign hash_rd = slot_rd[HASH_W-1:0];

  // Slot under inspection.
  logic [9:0] cur_slot;
  logic [10:0] cur_pos;
  logic [9:0] in_base;
  logic [10:0] base_sum;
  logic [9:0] nbase;
  logic [12:0] b5;
  logic [13:0] fill5, mask3;
  logic [10:0] fill_inc;

  always_comb begin
    cur_slot = base_r + {6'd0, k_r};
    cur_pos = pos_r;
    in_base = in_hash[9:0] & mask_r;
    b5 = {3'd0, base_r} * 13'd5;
    nbase = 10'(b5 + 13'd1 + 13'((pert_r >> PERTURB_STEP))) & mask_r;
    base_sum = {1'b0, nbase} + 11'(LINEAR_RUN);
    fill_inc = fill_r + 11'd1;
    fill5 = {3'd0, fill_inc} * 14'd5;
    mask3 = {4'd0, mask_r} * 14'd3;
  end

  // Read address: probe slot or scan position.
  assign raddr = (cmd_r == CMD_NEXT) ? cur_pos[9:0] : cur_slot;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r; used_nxt = used_r;
    pert_nxt = pert_r; base_nxt = base_r; k_nxt = k_r; run_nxt = run_r;
    round_nxt = round_r; pos_nxt = pos_r;
    tomb_nxt = tomb_r; tseen_nxt = tseen_r;
    wslot_nxt = wslot_r; wmark_nxt = wmark_r; wkh_nxt = wkh_r;
    clr_nxt = clr_r;
    ov_nxt = 1'b0;
    st_nxt = st_r; si_nxt = si_r; kh_sel_nxt = kh_sel_r; np_nxt = np_r; gw_nxt = gw_r;
    mark_we = 1'b0; mark_wa = wslot_r; mark_wd = wmark_r; kh_we = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mark_we = 1'b1; mark_wa = clr_r[9:0]; mark_wd = MARK_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IDX_W+1)'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          pert_nxt = in_hash;
          base_nxt = in_base;
          k_nxt = '0;
          run_nxt = ({1'b0, in_base} + 11'(LINEAR_RUN) <= {1'b0, mask_r})
                    ? 4'(LINEAR_RUN) : 4'd0;
          round_nxt = '0;
          pos_nxt = in_position;
          tseen_nxt = 1'b0; tomb_nxt = '0;
          st_nxt = ST_DONE; si_nxt = '0; kh_sel_nxt = 1'b0; np_nxt = '0; gw_nxt = 1'b0;
          wkh_nxt = 1'b0;
          if (in_command == CMD_NEXT && in_position > {1'b0, mask_r}) begin
            st_nxt = ST_END;
            np_nxt = (in_position == 11'h7FF) ? 11'h7FF : in_position + 11'd1;
            state_nxt = S_REPLY;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (cmd_r == CMD_NEXT) begin
          if (mark_rd == MARK_ACTIVE) begin
            st_nxt = ST_FOUND; si_nxt = pos_r[9:0]; kh_sel_nxt = 1'b1;
            np_nxt = pos_r + 11'd1;
            state_nxt = S_REPLY;
          end else if (pos_r + 11'd1 > {1'b0, mask_r}) begin
            st_nxt = ST_END; np_nxt = pos_r + 11'd2;
            state_nxt = S_REPLY;
          end else begin
            pos_nxt = pos_r + 11'd1;
            state_nxt = S_READ;
          end
        end else if (mark_rd == MARK_EMPTY) begin
          if (cmd_r == CMD_ADD && tseen_r) begin
            wslot_nxt = tomb_r; wmark_nxt = MARK_ACTIVE; wkh_nxt = 1'b1;
            used_nxt = used_r + 11'd1;
            st_nxt = ST_DONE; si_nxt = tomb_r;
            state_nxt = S_WRITE;
          end else if (cmd_r == CMD_ADD && fill_r < {1'b0, mask_r}) begin
            wslot_nxt = cur_slot; wmark_nxt = MARK_ACTIVE; wkh_nxt = 1'b1;
            fill_nxt = fill_inc; used_nxt = used_r + 11'd1;
            gw_nxt = fill5 >= mask3;
            st_nxt = ST_DONE; si_nxt = cur_slot;
            state_nxt = S_WRITE;
          end else begin
            st_nxt = (cmd_r == CMD_ADD) ? ST_FULL : ST_MISS;
            state_nxt = S_REPLY;
          end
        end else if (mark_rd == MARK_ACTIVE && hash_rd == hash_r && key_rd == key_r) begin
          si_nxt = cur_slot;
          if (cmd_r == CMD_DISCARD) begin
            wslot_nxt = cur_slot; wmark_nxt = MARK_TOMB; wkh_nxt = 1'b0;
            if (used_r != '0) used_nxt = used_r - 11'd1;
            st_nxt = ST_DONE;
            state_nxt = S_WRITE;
          end else begin
            st_nxt = ST_FOUND;
            state_nxt = S_REPLY;
          end
        end else begin
          if (mark_rd == MARK_TOMB) begin
            tomb_nxt = cur_slot; tseen_nxt = 1'b1;
          end
          if (k_r < run_r) begin
            k_nxt = k_r + 4'd1;
            state_nxt = S_READ;
          end else if (round_r == ROUND_W'(ROUND_LIMIT - 1)) begin
            st_nxt = (cmd_r == CMD_ADD) ? ST_FULL : ST_MISS;
            state_nxt = S_REPLY;
          end else begin
            round_nxt = round_r + 1'b1;
            pert_nxt = pert_r >> PERTURB_STEP;
            base_nxt = nbase;
            k_nxt = '0;
            run_nxt = (base_sum <= {1'b0, mask_r}) ? 4'(LINEAR_RUN) : 4'd0;
            state_nxt = S_READ;
          end
        end
      end
      S_WRITE: begin
        mark_we = 1'b1; kh_we = wkh_r;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      mask_r <= 10'd7;
      fill_r <= '0;
      used_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (cfg_we) mask_r <= cfg_data;
      fill_r <= fill_nxt;
      used_r <= used_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Request payload and probe registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_command;
      key_r <= in_key;
      hash_r <= in_hash;
    end
    pert_r <= pert_nxt; base_r <= base_nxt; k_r <= k_nxt; run_r <= run_nxt;
    round_r <= round_nxt; pos_r <= pos_nxt;
    tomb_r <= tomb_nxt; tseen_r <= tseen_nxt;
    wslot_r <= wslot_nxt; wmark_r <= wmark_nxt; wkh_r <= wkh_nxt;
    st_r <= st_nxt; si_r <= si_nxt; kh_sel_r <= kh_sel_nxt; np_r <= np_nxt; gw_r <= gw_nxt;
  end

  // Returned key and hash are held from the found slot's read.
  logic [31:0] ko_r;
  logic [63:0] ho_r;
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      ko_r <= key_rd;
      ho_r <= hash_rd;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_slot_index = si_r;
  assign out_key_out = kh_sel_r ? ko_r : 32'd0;
  assign out_hash_out = kh_sel_r ? ho_r : 64'd0;
  assign out_next_position = np_r;
  assign out_used_total = used_r;
  assign out_grow_wanted = gw_r;
endmodule
`default_nettype wire

FILE: rtl/oahs_ram.sv
`default_nettype none
module oahs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
